FILE: hw/rtl/lfu_cache_table_defines.svh
// assertion macros used by lfu_cache_table
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// same-cycle implication
`define LCT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lct: same-cycle check failed");

// next-cycle implication
`define LCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lct: next-cycle check failed");

`endif

FILE: hw/rtl/lct_pkg.sv
`timescale 1ns / 1ps

package lct_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WIN_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int CNT_W   = 16;
   localparam int TOUCH_W = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // one slot of the tag table
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [CNT_W-1:0]   count;
      logic [TOUCH_W-1:0] touch;
   } entry_type;

   // store write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } store_wr_type;

   // sequencer to scan unit
   typedef struct packed {
      logic             start;
      logic             step;
      logic             first;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   // scan unit results
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] found;
      logic             have_free;
      logic [IDX_W-1:0] free_idx;
      logic [IDX_W-1:0] victim;
   } scan_res_type;

endpackage

FILE: hw/rtl/lct_store.sv
`timescale 1ns / 1ps

module lct_store
   import lct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry,
   input  store_wr_type     wr
);

   logic [ENTRIES-1:0] valid_ff;
   entry_type          slot_ff [ENTRIES];

   // single read port, valid taken from the flag bits
   always_comb begin
      rd_entry       = slot_ff[rd_idx];
      rd_entry.valid = valid_ff[rd_idx];
   end

   // valid flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= wr.data.valid;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_ff[wr.idx] <= wr.data;
      end
   end

endmodule

FILE: hw/rtl/lct_scan.sv
`timescale 1ns / 1ps

module lct_scan
   import lct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  scan_ctl_type       ctl,
   input  entry_type          rd_entry,
   input  logic [KEY_W-1:0]   key,
   input  logic [TOUCH_W-1:0] touch_clock,
   output scan_res_type       res
);

   logic               hit_ff, hit_in;
   logic               have_free_ff, have_free_in;
   logic [IDX_W-1:0]   found_ff, found_in;
   logic [IDX_W-1:0]   free_ff, free_in;
   logic [IDX_W-1:0]   victim_ff, victim_in;
   logic [CNT_W-1:0]   best_cnt_ff, best_cnt_in;
   logic [TOUCH_W-1:0] best_age_ff, best_age_in;
   logic [TOUCH_W-1:0] age;
   logic               older;

   // shared compare unit: age against clock, then count and age ordering
   assign age   = touch_clock - rd_entry.touch;
   assign older = (rd_entry.count < best_cnt_ff) ||
                  ((rd_entry.count == best_cnt_ff) && (age > best_age_ff));

   // one slot per step
   always_comb begin
      hit_in       = hit_ff;
      have_free_in = have_free_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      victim_in    = victim_ff;
      best_cnt_in  = best_cnt_ff;
      best_age_in  = best_age_ff;
      if (ctl.start) begin
         hit_in       = 1'b0;
         have_free_in = 1'b0;
      end else if (ctl.step) begin
         if (rd_entry.valid) begin
            if (!hit_ff && (rd_entry.key == key)) begin
               hit_in   = 1'b1;
               found_in = ctl.idx;
            end
         end else if (!have_free_ff) begin
            have_free_in = 1'b1;
            free_in      = ctl.idx;
         end
         // victim only matters when every slot in the window is valid
         if (ctl.first || older) begin
            victim_in   = ctl.idx;
            best_cnt_in = rd_entry.count;
            best_age_in = age;
         end
      end
   end

   // search flags
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         have_free_ff <= 1'b0;
      end else begin
         hit_ff       <= hit_in;
         have_free_ff <= have_free_in;
      end
   end

   // search payload
   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      free_ff     <= free_in;
      victim_ff   <= victim_in;
      best_cnt_ff <= best_cnt_in;
      best_age_ff <= best_age_in;
   end

   assign res.hit       = hit_ff;
   assign res.found     = found_ff;
   assign res.have_free = have_free_ff;
   assign res.free_idx  = free_ff;
   assign res.victim    = victim_ff;

endmodule

FILE: hw/rtl/lfu_cache_table.sv
`timescale 1ns / 1ps
// channel   | signals                                         | direction
// req       | req_valid req_ready req_command req_lookup_key  | in
//           | req_write_value                                 |
// rsp       | rsp_valid rsp_ready rsp_hit rsp_read_value      | out
//           | rsp_evicted                                     |
// csr       | csr_valid csr_ready csr_capacity_in_use         | in
//
// an item is taken, its slot window W (capacity, at most 16) is scanned
// one slot per cycle through the shared key and victim compare unit, and
// then the table is updated at the hit, first free or victim slot.
// reset clears the valid flags, the touch clock and sets capacity to 16.
// the result sits in an output register; the next item is taken while it
// waits, and the table update stalls only if the previous result is unread.

`include "lfu_cache_table_defines.svh"

module lfu_cache_table
   import lct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [KEY_W-1:0] req_lookup_key,
   input  logic [VAL_W-1:0] req_write_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_hit,
   output logic [VAL_W-1:0] rsp_read_value,
   output logic             rsp_evicted,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_capacity_in_use
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [TOUCH_W-1:0] touch_clock_ff, touch_clock_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VAL_W-1:0]   val_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_evicted_ff, rsp_evicted_in;

   logic [WIN_W-1:0]   win;
   logic               scan_last;
   logic               req_xfer;
   logic               out_free;
   logic [IDX_W-1:0]   dst;
   logic [IDX_W-1:0]   rd_idx;
   entry_type          rd_entry;
   store_wr_type       wr;
   scan_ctl_type       scan_ctl;
   scan_res_type       scan_res;

   // slot window
   assign win = (int'(cap_ff) > ENTRIES) ? WIN_W'(ENTRIES) : WIN_W'(cap_ff);
   assign scan_last = ((WIN_W'(scan_idx_ff) + WIN_W'(1)) == win);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_capacity_in_use;
      end
   end

   // target slot: hit slot, else first free, else victim
   always_comb begin
      if (scan_res.hit) begin
         dst = scan_res.found;
      end else if (scan_res.have_free) begin
         dst = scan_res.free_idx;
      end else begin
         dst = scan_res.victim;
      end
   end

   assign rd_idx = (state_ff == ST_SCAN) ? scan_idx_ff : dst;

   lct_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   // scan control
   always_comb begin
      scan_ctl.start = req_xfer;
      scan_ctl.step  = (state_ff == ST_SCAN);
      scan_ctl.first = (scan_idx_ff == '0);
      scan_ctl.idx   = scan_idx_ff;
   end

   lct_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .rd_entry    (rd_entry),
      .key         (key_ff),
      .touch_clock (touch_clock_ff),
      .res         (scan_res)
   );

   // sequencer, table update and result
   always_comb begin
      state_in       = state_ff;
      scan_idx_in    = scan_idx_ff;
      touch_clock_in = touch_clock_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      wr.en          = 1'b0;
      wr.idx         = dst;
      wr.data.valid  = 1'b1;
      wr.data.touch  = touch_clock_ff;
      if (scan_res.hit) begin
         wr.data.key   = rd_entry.key;
         wr.data.value = (cmd_ff == CMD_PUT) ? val_ff : rd_entry.value;
         wr.data.count = (rd_entry.count == COUNT_MAX) ? COUNT_MAX
                                                       : rd_entry.count + CNT_W'(1);
      end else begin
         wr.data.key   = key_ff;
         wr.data.value = val_ff;
         wr.data.count = CNT_W'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               scan_idx_in = '0;
               state_in    = (win == '0) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_WRITE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               wr.en = scan_res.hit || ((cmd_ff == CMD_PUT) && (win != '0));
               if (wr.en) begin
                  touch_clock_in = touch_clock_ff + TOUCH_W'(1);
               end
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = scan_res.hit;
               rsp_value_in   = (scan_res.hit && (cmd_ff == CMD_GET)) ? rd_entry.value
                                                                       : '0;
               rsp_evicted_in = (cmd_ff == CMD_PUT) && !scan_res.hit &&
                                (win != '0) && !scan_res.have_free;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         touch_clock_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         scan_idx_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         touch_clock_ff <= touch_clock_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_idx_ff    <= scan_idx_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= req_command;
         key_ff <= req_lookup_key;
         val_ff <= req_write_value;
      end
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   // checks
   `LCT_ASSERT_NEXT(a_leave_idle, clock, reset, req_valid && req_ready, state_ff != ST_IDLE)
   `LCT_ASSERT_SAME(a_scan_in_window, clock, reset, state_ff == ST_SCAN, WIN_W'(scan_idx_ff) < win)
   `LCT_ASSERT_SAME(a_no_evict_on_hit, clock, reset, rsp_valid, !(rsp_hit && rsp_evicted))
   `LCT_ASSERT_NEXT(a_touch_advance, clock, reset, wr.en, touch_clock_ff == $past(touch_clock_ff) + TOUCH_W'(1))

endmodule
